[sv/fpf_pkg.sv]
// Package for the fourth-power-free word check: sizes, codes and the
// structs that travel between the pipeline stages. Depends on nothing.
package fpf_pkg;

    localparam int MAX_LEN   = 32;
    localparam int WORD_BITS = 32;
    localparam int EFF_MAX   = (MAX_LEN < WORD_BITS) ? MAX_LEN : WORD_BITS;
    localparam int LEN_W     = 6;
    localparam int MAX_K     = EFF_MAX / 4;
    localparam int POS_W     = $clog2(WORD_BITS);
    localparam int PER_W     = 4;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [PER_W-1:0]     t_per;

    localparam t_len LEN_RESET = t_len'(16);

    typedef enum logic [1:0] {
        REASON_NONE,
        REASON_TOP,
        REASON_ADJ,
        REASON_REPEAT
    } t_reason;

    // Early rejections found in the first stage.
    typedef struct packed {
        logic top_set;
        logic adj_set;
    } t_flags;

    // One bit vector per candidate period, index 0 is period 1.
    typedef logic [MAX_K-1:0][WORD_BITS-1:0] t_runs;

    typedef struct packed {
        logic [MAX_K-1:0]            any;
        logic [MAX_K-1:0][POS_W-1:0] top;
    } t_hits;

    typedef struct packed {
        logic    accepted;
        t_reason reason;
        t_per    period;
        t_pos    witness;
    } t_result;

endpackage

[sv/fpf_if.sv]
// Handshake channels of the fourth-power-free word check: input word,
// result word and configuration write. Depends on fpf_pkg.
interface fpf_word_if;
    logic          valid;
    logic          ready;
    fpf_pkg::t_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface fpf_result_if;
    logic          valid;
    logic          ready;
    logic          accepted;
    logic [1:0]    reject_reason;
    fpf_pkg::t_per repeat_period;
    fpf_pkg::t_pos witness_position;

    modport source (output valid, output accepted, output reject_reason,
                    output repeat_period, output witness_position, input ready);
    modport sink   (input valid, input accepted, input reject_reason,
                    input repeat_period, input witness_position, output ready);
endinterface

interface fpf_cfg_if;
    logic          valid;
    logic          ready;
    fpf_pkg::t_len word_length;

    modport source (output valid, output word_length, input ready);
    modport sink   (input valid, input word_length, output ready);
endinterface

[sv/fpf_mark.sv]
// First stage: masks the word to its length, finds the early rejections
// and marks the positions that match at distances k, 2k and 3k. Uses fpf_pkg.
module fpf_mark (
    input  logic            i_clk,
    input  logic            i_en,
    input  fpf_pkg::t_word  i_word,
    input  fpf_pkg::t_len   i_len,
    output fpf_pkg::t_flags o_flags,
    output fpf_pkg::t_runs  o_marks
);

    fpf_pkg::t_word  w;
    fpf_pkg::t_flags n_flags;
    fpf_pkg::t_runs  n_marks;
    fpf_pkg::t_flags r_flags;
    fpf_pkg::t_runs  r_marks;

    always_comb begin
        for (int i = 0; i < fpf_pkg::WORD_BITS; i++) begin
            w[i] = i_word[i] & (i < int'(i_len));
        end
        n_flags.top_set = 1'b0;
        for (int i = 0; i < fpf_pkg::WORD_BITS; i++) begin
            if (i + 1 == int'(i_len)) begin
                n_flags.top_set = w[i];
            end
        end
        n_flags.adj_set = |(w[fpf_pkg::WORD_BITS-1:1] & w[fpf_pkg::WORD_BITS-2:0]);
        // A mark needs p+3k inside the word; periods above length/4 stay empty.
        for (int k = 1; k <= fpf_pkg::MAX_K; k++) begin
            for (int p = 0; p < fpf_pkg::WORD_BITS; p++) begin
                n_marks[k-1][p] = 1'b0;
                if ((4 * k <= int'(i_len)) && (p + 3 * k < int'(i_len))) begin
                    n_marks[k-1][p] = (w[p] == w[p+k]) && (w[p] == w[p+2*k])
                                   && (w[p] == w[p+3*k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
            r_marks <= n_marks;
        end
    end

    assign o_flags = r_flags;
    assign o_marks = r_marks;

endmodule

[sv/fpf_run.sv]
// Second stage: for each period k keeps the positions that start k marks
// in a row. Uses fpf_pkg.
module fpf_run (
    input  logic            i_clk,
    input  logic            i_en,
    input  fpf_pkg::t_flags i_flags,
    input  fpf_pkg::t_runs  i_marks,
    output fpf_pkg::t_flags o_flags,
    output fpf_pkg::t_runs  o_runs
);

    fpf_pkg::t_runs  n_runs;
    fpf_pkg::t_runs  r_runs;
    fpf_pkg::t_flags r_flags;

    always_comb begin
        for (int k = 1; k <= fpf_pkg::MAX_K; k++) begin
            for (int p = 0; p < fpf_pkg::WORD_BITS; p++) begin
                n_runs[k-1][p] = 1'b1;
                for (int j = 0; j < k; j++) begin
                    if (p + j < fpf_pkg::WORD_BITS) begin
                        n_runs[k-1][p] = n_runs[k-1][p] & i_marks[k-1][p+j];
                    end else begin
                        n_runs[k-1][p] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_runs  <= n_runs;
            r_flags <= i_flags;
        end
    end

    assign o_runs  = r_runs;
    assign o_flags = r_flags;

endmodule

[sv/fpf_pick.sv]
// Third and fourth stages: finds the highest run start of every period,
// then picks the smallest period and forms the result. Uses fpf_pkg.
module fpf_pick (
    input  logic             i_clk,
    input  logic             i_en3,
    input  logic             i_en4,
    input  fpf_pkg::t_flags  i_flags,
    input  fpf_pkg::t_runs   i_runs,
    output fpf_pkg::t_result o_result
);

    fpf_pkg::t_hits   n_hits;
    fpf_pkg::t_hits   r_hits;
    fpf_pkg::t_flags  r_flags;
    fpf_pkg::t_result n_result;
    fpf_pkg::t_result r_result;

    always_comb begin
        for (int k = 0; k < fpf_pkg::MAX_K; k++) begin
            n_hits.any[k] = |i_runs[k];
            n_hits.top[k] = '0;
            for (int p = 0; p < fpf_pkg::WORD_BITS; p++) begin
                if (i_runs[k][p]) begin
                    n_hits.top[k] = fpf_pkg::POS_W'(p);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_hits  <= n_hits;
            r_flags <= i_flags;
        end
    end

    always_comb begin
        n_result.accepted = 1'b1;
        n_result.reason   = fpf_pkg::REASON_NONE;
        n_result.period   = '0;
        n_result.witness  = '0;
        priority if (r_flags.top_set) begin
            n_result.accepted = 1'b0;
            n_result.reason   = fpf_pkg::REASON_TOP;
        end else if (r_flags.adj_set) begin
            n_result.accepted = 1'b0;
            n_result.reason   = fpf_pkg::REASON_ADJ;
        end else begin
            // Walk down so the smallest period found wins.
            for (int k = fpf_pkg::MAX_K - 1; k >= 0; k--) begin
                if (r_hits.any[k]) begin
                    n_result.accepted = 1'b0;
                    n_result.reason   = fpf_pkg::REASON_REPEAT;
                    n_result.period   = fpf_pkg::PER_W'(k + 1);
                    n_result.witness  = r_hits.top[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

[sv/fourth_power_free_word_check_top.sv]
// Top level of the fourth-power-free word check: length register, stage
// valid bits and the three pipeline modules. Uses fpf_pkg, fpf_if.sv,
// fpf_mark, fpf_run and fpf_pick.
//
//   channel      direction  payload
//   i_word_ch    in         word (32 bits)
//   o_result_ch  out        accepted, reject_reason, repeat_period, witness_position
//   i_cfg_ch     in         word_length (6 bits), always ready
//
// An accepted word passes through the marks, runs, hits and result registers
// before its result appears on the output. One word can be accepted every
// cycle while the result channel is ready. The four stages are: masking and
// matching, run detection, per-period highest-position search, and the
// final choice of the smallest period. Reset clears all stage valid bits and
// sets the length to 16. A stalled result holds in the last stage; a stage
// with a bubble still takes the next word, so a stall loses nothing.
module fourth_power_free_word_check_top (
    input logic          i_clk,
    input logic          i_rst_n,
    fpf_word_if.sink     i_word_ch,
    fpf_result_if.source o_result_ch,
    fpf_cfg_if.sink      i_cfg_ch
);

    localparam int STAGES = 4;

    fpf_pkg::t_len    r_len;
    fpf_pkg::t_len    eff_len;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] en;

    fpf_pkg::t_flags  flags1;
    fpf_pkg::t_flags  flags2;
    fpf_pkg::t_runs   marks;
    fpf_pkg::t_runs   runs;
    fpf_pkg::t_result result;

    // The configuration write is taken at any time; the user writes it only
    // while the pipeline is empty.
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= fpf_pkg::LEN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_len <= i_cfg_ch.word_length;
        end
    end

    // A length of zero counts as one; longer than the word counts as full.
    always_comb begin
        priority if (r_len == '0) begin
            eff_len = fpf_pkg::t_len'(1);
        end else if (int'(r_len) > fpf_pkg::EFF_MAX) begin
            eff_len = fpf_pkg::t_len'(fpf_pkg::EFF_MAX);
        end else begin
            eff_len = r_len;
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || o_result_ch.ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
        n_vld[0] = en[0] ? i_word_ch.valid : r_vld[0];
        for (int s = 1; s < STAGES; s++) begin
            n_vld[s] = en[s] ? r_vld[s-1] : r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_word_ch.ready = en[0];

    fpf_mark u_mark (
        .i_clk   (i_clk),
        .i_en    (en[0]),
        .i_word  (i_word_ch.word),
        .i_len   (eff_len),
        .o_flags (flags1),
        .o_marks (marks)
    );

    fpf_run u_run (
        .i_clk   (i_clk),
        .i_en    (en[1]),
        .i_flags (flags1),
        .i_marks (marks),
        .o_flags (flags2),
        .o_runs  (runs)
    );

    fpf_pick u_pick (
        .i_clk    (i_clk),
        .i_en3    (en[2]),
        .i_en4    (en[3]),
        .i_flags  (flags2),
        .i_runs   (runs),
        .o_result (result)
    );

    assign o_result_ch.valid            = r_vld[STAGES-1];
    assign o_result_ch.accepted         = result.accepted;
    assign o_result_ch.reject_reason    = result.reason;
    assign o_result_ch.repeat_period    = result.period;
    assign o_result_ch.witness_position = result.witness;

`ifndef SYNTH
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_word_ch.valid && i_word_ch.ready |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] && result.accepted |-> result.reason == fpf_pkg::REASON_NONE)
        else $error("accepted word carries a reject reason");

    a_no_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] && result.reason != fpf_pkg::REASON_REPEAT
        |-> result.period == '0 && result.witness == '0)
        else $error("period or witness set without a repeat");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] && result.reason == fpf_pkg::REASON_REPEAT
        |-> result.period != '0 && int'(result.period) <= fpf_pkg::MAX_K
            && !result.accepted)
        else $error("repeat reported with a bad period");
`endif

endmodule

[bench/fourth_power_free_word_check_top_test.sv]
// Self-checking bench for fourth_power_free_word_check_top: drives candidate
// words and length writes, predicts each verdict and compares it field by field.
// Depends on fpf_pkg, the channel interfaces in fpf_if.sv and the top level.
module fourth_power_free_word_check_top_test;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpf_word_if   word_ch ();
    fpf_result_if result_ch ();
    fpf_cfg_if    cfg_ch ();

    fourth_power_free_word_check_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word_ch   (word_ch),
        .o_result_ch (result_ch),
        .i_cfg_ch    (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // Words waiting to be offered, and verdicts predicted for accepted words
    // whose results have not come back yet.
    fpf_pkg::t_word   queued_words[$];
    fpf_pkg::t_result pending_verdicts[$];

    // Length as the block holds it; it only changes while the block is idle.
    fpf_pkg::t_len length_shadow = fpf_pkg::LEN_RESET;

    // When set, neither side idles. Written at the falling edge only.
    bit no_idle = 1'b0;

    // The receiver starts one long hold-off each time this count moves.
    int long_hold_req  = 0;
    int long_hold_seen = 0;

    int mismatch_count  = 0;
    int words_checked   = 0;
    int results_checked = 0;
    int lengths_written = 0;
    int reason_tally[4] = '{0, 0, 0, 0};

    // The register saturates: zero acts as one, anything past the word width
    // acts as the word width.
    function automatic int unsigned clamp_length(fpf_pkg::t_len len);
        int unsigned n;
        n = len;
        if (n < 1) n = 1;
        if (n > fpf_pkg::EFF_MAX) n = fpf_pkg::EFF_MAX;
        return n;
    endfunction

    // Positions p below n-d where digit p equals digit p+d.
    function automatic logic [63:0] agree_mask(logic [63:0] w, int unsigned n, int unsigned d);
        logic [63:0] lim;
        lim = (64'd1 << (n - d)) - 64'd1;
        return ~(w ^ (w >> d)) & lim;
    endfunction

    // Verdict for one word at the given length. The rules are tried in order
    // and the first one that fails decides the reason.
    function automatic fpf_pkg::t_result predict_verdict(fpf_pkg::t_word raw,
                                                         fpf_pkg::t_len len);
        fpf_pkg::t_result r;
        int unsigned      n;
        int unsigned      k;
        int unsigned      j;
        int unsigned      top;
        logic [63:0]      w;
        logic [63:0]      marks;
        logic [63:0]      run;
        n = clamp_length(len);
        w = {32'd0, raw} & ((64'd1 << n) - 64'd1);
        r.accepted = 1'b1;
        r.reason   = fpf_pkg::REASON_NONE;
        r.period   = '0;
        r.witness  = '0;
        if (w[n-1]) begin
            r.accepted = 1'b0;
            r.reason   = fpf_pkg::REASON_TOP;
        end else if ((w & (w << 1)) != 64'd0) begin
            r.accepted = 1'b0;
            r.reason   = fpf_pkg::REASON_ADJ;
        end else if (n > 3) begin
            for (k = 1; k <= n / 4; k++) begin
                marks = agree_mask(w, n, k) & agree_mask(w, n, 2 * k)
                      & agree_mask(w, n, 3 * k);
                // A fourfold repeat of period k needs k marks in a row.
                run = marks;
                for (j = 1; j < k; j++) run &= marks >> j;
                if (run != 64'd0) begin
                    top = 0;
                    for (j = 0; j < n; j++) if (run[j]) top = j;
                    r.accepted = 1'b0;
                    r.reason   = fpf_pkg::REASON_REPEAT;
                    r.period   = fpf_pkg::t_per'(k);
                    r.witness  = fpf_pkg::t_pos'(top);
                    break;
                end
            end
        end
        return r;
    endfunction

    // Most candidates are well formed (top digit clear, no two set digits
    // side by side) so that the repeat search is reached. Some are built from
    // a repeated block, now and then with one digit flipped, and the rest is
    // plain noise. Digits at or above the length are left random throughout.
    function automatic fpf_pkg::t_word make_candidate(int unsigned n);
        fpf_pkg::t_word w;
        fpf_pkg::t_word block;
        int unsigned    pick;
        int unsigned    k;
        int unsigned    i;
        w    = fpf_pkg::t_word'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 2) return w;
        if (pick < 6) begin
            for (i = 0; i < n; i++)
                w[i] = (i > 0 && w[i-1]) ? 1'b0 : ($urandom_range(0, 2) == 0);
        end else begin
            k = (n >= 4) ? $urandom_range(1, n / 4) : 1;
            block = fpf_pkg::t_word'($urandom);
            for (i = 1; i < k; i++) if (block[i-1]) block[i] = 1'b0;
            if (k == 1 || block[0]) block[k-1] = (k == 1) ? 1'b0 : 1'b0;
            for (i = 0; i < n; i++) w[i] = block[i % k];
            if ($urandom_range(0, 2) == 0) begin
                i = $urandom_range(0, n - 1);
                w[i] = ~w[i];
            end
        end
        if ($urandom_range(0, 7) != 0) w[n-1] = 1'b0;
        return w;
    endfunction

    // Idle cycles a side waits before its next word.
    function automatic int unsigned draw_idle();
        if (no_idle) return 0;
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("result %0d: %s is %0d, expected %0d", results_checked, what, got, want);
        mismatch_count++;
    endtask

    // Sender. An accepted word gets its verdict predicted on the spot; the
    // next word is offered once the drawn gap has run out.
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin : word_driver
        logic             offer;
        fpf_pkg::t_word   next_word;
        fpf_pkg::t_result verdict;
        if (!i_rst_n) begin
            word_ch.valid <= 1'b0;
            word_ch.word  <= '0;
            send_gap = 0;
        end else begin
            offer     = word_ch.valid;
            next_word = word_ch.word;
            if (word_ch.valid && word_ch.ready) begin
                verdict = predict_verdict(word_ch.word, length_shadow);
                pending_verdicts.push_back(verdict);
                reason_tally[verdict.reason]++;
                words_checked++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_words.size() > 0) begin
                    next_word = queued_words.pop_front();
                    offer     = 1'b1;
                    send_gap  = draw_idle();
                end
            end
            word_ch.valid <= offer;
            word_ch.word  <= next_word;
        end
    end

    // Receiver. Every accepted result is held against the oldest prediction.
    // After each one it stalls for a drawn number of cycles, and on request
    // it holds ready low for a long stretch so that the pipeline backs up.
    int unsigned recv_stall = 0;

    always @(posedge i_clk) begin : result_monitor
        fpf_pkg::t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_checked++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 1, 0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (result_ch.accepted !== want.accepted)
                        report_mismatch("accepted", result_ch.accepted, want.accepted);
                    if (result_ch.reject_reason !== 2'(want.reason))
                        report_mismatch("reject_reason", result_ch.reject_reason,
                                        want.reason);
                    if (result_ch.repeat_period !== want.period)
                        report_mismatch("repeat_period", result_ch.repeat_period,
                                        want.period);
                    if (result_ch.witness_position !== want.witness)
                        report_mismatch("witness_position", result_ch.witness_position,
                                        want.witness);
                end
                recv_stall = draw_idle();
            end
            if (long_hold_seen != long_hold_req) begin
                long_hold_seen = long_hold_req;
                recv_stall     = 200;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Waits at falling edges until every queued word has been taken and
    // every verdict has come back, then lets the pipeline drain a little.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_words.size() != 0 || word_ch.valid || pending_verdicts.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // One write on the configuration channel; only called while idle.
    task automatic write_length(fpf_pkg::t_len value);
        @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.word_length <= value;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        length_shadow = value;
        lengths_written++;
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic directed_words(fpf_pkg::t_len value, bit write, fpf_pkg::t_word words[$]);
        if (write) write_length(value);
        foreach (words[i]) queued_words.push_back(words[i]);
        wait_idle();
    endtask

    task automatic random_phase(fpf_pkg::t_len value, int count, bit fast, bit hold);
        int unsigned n;
        write_length(value);
        n       = clamp_length(value);
        no_idle = fast;
        if (hold) long_hold_req++;
        repeat (count) queued_words.push_back(make_candidate(n));
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.word_length <= fpf_pkg::LEN_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset length of 16: all-clear and all-set words, the top digit
        // alone, adjacency just below the top, periods one to three, a word
        // with no repeat, and garbage above the length that must be ignored.
        directed_words(fpf_pkg::LEN_RESET, 1'b0, {32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h0000_8000, 32'h0000_7FFF,
                                                  32'h0000_0003, 32'h0000_5555,
                                                  32'h0000_2492, 32'h0000_1249,
                                                  32'h0000_0001, 32'hFFFF_1249,
                                                  32'h0000_4A52});
        // Smallest length, and zero which acts as one.
        directed_words(6'd1, 1'b1, {32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFE});
        directed_words(6'd0, 1'b1, {32'h0000_0001, 32'h0000_0000});
        // Below four digits no repeat search is made.
        directed_words(6'd3, 1'b1, {32'h0000_0000, 32'h0000_0002, 32'h0000_0005});
        directed_words(6'd4, 1'b1, {32'h0000_0000, 32'h0000_0005});
        // The largest register value saturates to the full word.
        directed_words(6'd63, 1'b1, {32'h5555_5555, 32'h2492_4924, 32'h7FFF_FFFF,
                                     32'h0000_0000});

        // Random phases over many lengths. The first runs without idling and
        // with a long receiver hold-off, so the pipeline fills and the input
        // stalls; each phase ends only once every result is back.
        random_phase(6'd32, 70, 1'b1, 1'b1);
        random_phase(6'd16, 70, 1'b0, 1'b0);
        random_phase(6'd4,  70, 1'b0, 1'b0);
        random_phase(6'd5,  70, 1'b0, 1'b0);
        random_phase(6'd31, 70, 1'b0, 1'b0);
        random_phase(6'd8,  70, 1'b0, 1'b0);
        random_phase(6'd12, 70, 1'b1, 1'b0);
        random_phase(6'd2,  70, 1'b0, 1'b0);
        random_phase(6'd20, 70, 1'b0, 1'b0);
        random_phase(6'd33, 70, 1'b0, 1'b0);
        random_phase(6'd24, 70, 1'b0, 1'b1);
        random_phase(6'd7,  70, 1'b0, 1'b0);
        random_phase(6'd17, 70, 1'b0, 1'b0);
        random_phase(6'd28, 70, 1'b0, 1'b0);
        random_phase(6'd10, 70, 1'b0, 1'b0);
        random_phase(6'd32, 70, 1'b1, 1'b0);

        repeat (8) @(negedge i_clk);
        $display("checked %0d words across %0d length writes (0 to 63, saturating)",
                 words_checked, lengths_written);
        $display("verdicts: %0d accepted, %0d top digit, %0d adjacent, %0d fourfold repeat",
                 reason_tally[fpf_pkg::REASON_NONE], reason_tally[fpf_pkg::REASON_TOP],
                 reason_tally[fpf_pkg::REASON_ADJ], reason_tally[fpf_pkg::REASON_REPEAT]);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every word waiting out the longest
    // gap on both sides, plus the long hold-offs and the phase drains.
    initial begin
        #(400000 * 12);
        $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
